// File: sv/bcs_pkg.sv
`default_nettype none
package bcs_pkg;

    localparam int unsigned STORE_BYTES_DEF = 8192;
    localparam int unsigned ROW_BYTES_DEF   = 80;

    localparam int SW_W     = 13;
    localparam int TW_W     = 11;
    localparam int LADDR_W  = 13;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 7;
    localparam int PIX_W    = 8;
    localparam int PROD_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIX_W-1:0] ALL_ONES = 8'hFF;
    localparam logic [2:0]       K_LAST   = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_W,
        CFG_SRC_H,
        CFG_DST_W,
        CFG_DST_H
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_LOAD,
        K_RENDER,
        K_FILL_BAD,
        K_FILL_OK
    } t_kind;

    typedef struct packed {
        logic [SW_W-1:0] sw;
        logic [SW_W-1:0] sh;
        logic [TW_W-1:0] tw;
        logic [TW_W-1:0] th;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic [LADDR_W-1:0] addr;
        logic [PIX_W-1:0]   value;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_CMP,
        ST_CROP,
        ST_ROW_MUL,
        ST_ROW_GO,
        ST_ROW_DIV,
        ST_ROW_BASE,
        ST_PIX_MUL,
        ST_PIX_GO,
        ST_PIX_DIV,
        ST_PIX_READ,
        ST_PIX_BIT,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

// File: sv/bitmap_cover_scaler_top.sv
`default_nettype none
// Port group  | Direction | Signals
// ------------+-----------+----------------------------------------------------
// request     | in        | i_start / o_busy, i_req_type, i_load_address,
//             |           | i_load_value, i_target_row, i_target_byte_column
// result      | out       | o_result_strobe, o_pixel_byte, o_config_valid
// config      | in        | i_cfg_we, i_cfg_idx, i_cfg_data
//
// A load beat is written to the store as the back end pops it. A render
// computes its quotients on the shared one-bit-per-cycle divider: one for
// the crop, one for the row and one per visible pixel.
// Results that need no scaling (bad sizes, outside the box) go straight to
// the emit state.
// Reset is synchronous and active low; the store holds no valid state.
// A two-entry queue lets requests arrive while the back end works; o_busy is
// high only while it is full. Results cannot be held off.
module bitmap_cover_scaler_top import bcs_pkg::*; #(
    parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
    parameter int unsigned ROW_BYTES   = ROW_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic                 i_req_type,
    input  wire logic [LADDR_W-1:0]   i_load_address,
    input  wire logic [PIX_W-1:0]     i_load_value,
    input  wire logic [ROW_W-1:0]     i_target_row,
    input  wire logic [COL_W-1:0]     i_target_byte_column,
    output logic                      o_result_strobe,
    output logic      [PIX_W-1:0]     o_pixel_byte,
    output logic                      o_config_valid,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [SW_W-1:0]      i_cfg_data
);

    t_cfg  r_cfg;
    t_head head;
    logic  pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sw <= SW_W'(1);
            r_cfg.sh <= SW_W'(1);
            r_cfg.tw <= TW_W'(1);
            r_cfg.th <= TW_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_W: r_cfg.sw <= i_cfg_data;
                CFG_SRC_H: r_cfg.sh <= i_cfg_data;
                CFG_DST_W: r_cfg.tw <= i_cfg_data[TW_W-1:0];
                CFG_DST_H: r_cfg.th <= i_cfg_data[TW_W-1:0];
                default: ;
            endcase
        end
    end

    bcs_front #(
        .STORE_BYTES (STORE_BYTES),
        .ROW_BYTES   (ROW_BYTES)
    ) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (i_start),
        .i_req_type           (i_req_type),
        .i_load_address       (i_load_address),
        .i_load_value         (i_load_value),
        .i_target_row         (i_target_row),
        .i_target_byte_column (i_target_byte_column),
        .i_cfg                (r_cfg),
        .i_pop                (pop),
        .o_busy               (o_busy),
        .o_head               (head)
    );

    bcs_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (head),
        .o_pop          (pop),
        .o_strobe       (o_result_strobe),
        .o_pixel_byte   (o_pixel_byte),
        .o_config_valid (o_config_valid)
    );

endmodule
`default_nettype wire

// File: sv/bcs_ram.sv
`default_nettype none
module bcs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: sv/bcs_div.sv
`default_nettype none
module bcs_div import bcs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [PROD_W-1:0] i_dividend,
    input  wire logic [SW_W-1:0]   i_divisor,
    output logic                   o_done,
    output logic      [PROD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(PROD_W);

    logic [PROD_W-1:0] r_quo;
    logic [SW_W-1:0]   r_rem;
    logic [SW_W-1:0]   r_dsr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [SW_W:0]     trial;
    logic              take;

    // Restoring division, one quotient bit per cycle; the dividend shifts out
    // of the top of r_quo as quotient bits shift in at the bottom.
    assign trial = {r_rem, r_quo[PROD_W-1]};
    assign take  = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[PROD_W-2:0], take};
            r_rem <= take ? SW_W'(trial - {1'b0, r_dsr}) : trial[SW_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// File: sv/bcs_front.sv
`default_nettype none
module bcs_front import bcs_pkg::*; #(
    parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
    parameter int unsigned ROW_BYTES   = ROW_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_req_type,
    input  wire logic [LADDR_W-1:0] i_load_address,
    input  wire logic [PIX_W-1:0]   i_load_value,
    input  wire logic [ROW_W-1:0]   i_target_row,
    input  wire logic [COL_W-1:0]   i_target_byte_column,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_pop,
    output logic                    o_busy,
    output t_head                   o_head
);

    logic [SW_W:0]       src_sum;
    logic [SW_W-3:0]     src_row_bytes;
    logic [TW_W:0]       dst_sum;
    logic [TW_W-3:0]     dst_row_bytes;
    logic [PROD_W-1:0]   store_need;
    logic                sizes_ok;
    logic                outside;
    logic                load_ok;
    logic                push;
    t_item               item;

    t_item               r_q [2];
    logic                r_wr;
    logic                r_rd;
    logic [1:0]          r_cnt;

    assign src_sum       = {1'b0, i_cfg.sw} + (SW_W + 1)'(7);
    assign src_row_bytes = src_sum[SW_W:3];
    assign dst_sum       = {1'b0, i_cfg.tw} + (TW_W + 1)'(7);
    assign dst_row_bytes = dst_sum[TW_W:3];
    assign store_need    = {11'b0, src_row_bytes} * {11'b0, i_cfg.sh};

    assign sizes_ok = (i_cfg.sw != '0) && (i_cfg.sh != '0) && (i_cfg.tw != '0)
                   && (i_cfg.th != '0) && (store_need <= PROD_W'(STORE_BYTES))
                   && ({1'b0, dst_row_bytes} <= (TW_W - 1)'(ROW_BYTES));
    assign outside  = ({1'b0, i_target_row} >= i_cfg.th)
                   || ({2'b0, i_target_byte_column} >= dst_row_bytes);
    assign load_ok  = 17'(i_load_address) < 17'(STORE_BYTES);

    always_comb begin
        item.addr  = i_load_address;
        item.value = i_load_value;
        item.row   = i_target_row;
        item.col   = i_target_byte_column;
        if (!i_req_type) begin
            item.kind = K_LOAD;
        end else if (!sizes_ok) begin
            item.kind = K_FILL_BAD;
        end else if (outside) begin
            item.kind = K_FILL_OK;
        end else begin
            item.kind = K_RENDER;
        end
    end

    // Loads beyond the store are taken and dropped here.
    assign push   = i_start && !o_busy && (i_req_type || load_ok);
    assign o_busy = r_cnt == 2'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= item;
        end
    end

    assign o_head.valid = r_cnt != '0;
    assign o_head.item  = r_q[r_rd];

endmodule
`default_nettype wire

// File: sv/bcs_back.sv
`default_nettype none
module bcs_back import bcs_pkg::*; #(
    parameter int unsigned STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire t_head            i_head,
    output logic                  o_pop,
    output logic                  o_strobe,
    output logic      [PIX_W-1:0] o_pixel_byte,
    output logic                  o_config_valid
);

    localparam int ADDR_W = $clog2(STORE_BYTES);

    t_state              r_state, n_state;
    logic                r_wd;
    logic [PROD_W-1:0]   r_pa, r_pb, r_prod, r_crop;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [SW_W-1:0]     r_sy, r_sx;
    logic [ADDR_W-1:0]   r_base;
    logic [2:0]          r_k;
    logic [PIX_W-1:0]    r_byte;
    logic                r_flag;

    logic [SW_W:0]       src_sum;
    logic [SW_W-3:0]     stride;
    logic [COL_W+2:0]    dx;
    logic                dx_skip;
    logic                cmp_ge;
    logic [PROD_W-1:0]   pa_full, pb_full;
    logic [PROD_W-1:0]   mul_a;
    logic [SW_W-1:0]     mul_b;
    logic [PROD_W+SW_W-1:0] mul_full;
    logic [PROD_W-1:0]   base_full;
    logic                div_start, div_done;
    logic [PROD_W-1:0]   div_dividend, div_q;
    logic [SW_W-1:0]     div_divisor;
    logic [SW_W-1:0]     sy_clamp, sx_clamp;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [PIX_W-1:0]    ram_rdata;
    logic                src_bit;

    assign src_sum = {1'b0, i_cfg.sw} + (SW_W + 1)'(7);
    assign stride  = src_sum[SW_W:3];
    assign dx      = {r_col, r_k};
    assign dx_skip = {1'b0, dx} >= i_cfg.tw;
    assign cmp_ge  = r_pa >= r_pb;
    assign pa_full = {13'b0, i_cfg.tw} * {11'b0, i_cfg.sh};
    assign pb_full = {13'b0, i_cfg.th} * {11'b0, i_cfg.sw};

    // One shared multiplier: the row step and every pixel step use it.
    always_comb begin
        mul_b = r_wd ? i_cfg.sw : i_cfg.sh;
        if (r_state == ST_ROW_MUL) begin
            mul_a = r_wd ? r_crop + PROD_W'(r_row) : PROD_W'(r_row);
        end else begin
            mul_a = r_wd ? PROD_W'(dx) : r_crop + PROD_W'(dx);
        end
    end
    assign mul_full  = {{SW_W{1'b0}}, mul_a} * {{PROD_W{1'b0}}, mul_b};
    assign base_full = {11'b0, r_sy} * {13'b0, stride};

    always_comb begin
        if (r_state == ST_CMP) begin
            div_dividend = cmp_ge ? r_pa : r_pb;
            div_divisor  = cmp_ge ? i_cfg.sw : i_cfg.sh;
        end else begin
            div_dividend = r_prod;
            div_divisor  = r_wd ? {2'b0, i_cfg.tw} : {2'b0, i_cfg.th};
        end
    end

    bcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign sy_clamp  = (div_q >= PROD_W'(i_cfg.sh)) ? i_cfg.sh - 1'b1 : div_q[SW_W-1:0];
    assign sx_clamp  = (div_q >= PROD_W'(i_cfg.sw)) ? i_cfg.sw - 1'b1 : div_q[SW_W-1:0];
    assign ram_raddr = r_base + ADDR_W'(r_sx[SW_W-1:3]);
    assign src_bit   = ram_rdata[K_LAST - r_sx[2:0]];

    bcs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(i_head.item.addr)),
        .i_wdata (i_head.item.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    case (i_head.item.kind)
                        K_LOAD:   n_state = ST_IDLE;
                        K_RENDER: n_state = ST_MUL_A;
                        default:  n_state = ST_EMIT;
                    endcase
                end
            end
            ST_MUL_A:    n_state = ST_MUL_B;
            ST_MUL_B:    n_state = ST_CMP;
            ST_CMP:      n_state = ST_CROP;
            ST_CROP:     n_state = div_done ? ST_ROW_MUL : ST_CROP;
            ST_ROW_MUL:  n_state = ST_ROW_GO;
            ST_ROW_GO:   n_state = ST_ROW_DIV;
            ST_ROW_DIV:  n_state = div_done ? ST_ROW_BASE : ST_ROW_DIV;
            ST_ROW_BASE: n_state = ST_PIX_MUL;
            ST_PIX_MUL: begin
                if (!dx_skip) begin
                    n_state = ST_PIX_GO;
                end else if (r_k == K_LAST) begin
                    n_state = ST_EMIT;
                end
            end
            ST_PIX_GO:   n_state = ST_PIX_DIV;
            ST_PIX_DIV:  n_state = div_done ? ST_PIX_READ : ST_PIX_DIV;
            ST_PIX_READ: n_state = ST_PIX_BIT;
            ST_PIX_BIT:  n_state = (r_k == K_LAST) ? ST_EMIT : ST_PIX_MUL;
            ST_EMIT:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == ST_IDLE) && i_head.valid;
        ram_we    = o_pop && (i_head.item.kind == K_LOAD);
        div_start = (r_state == ST_CMP) || (r_state == ST_ROW_GO) || (r_state == ST_PIX_GO);
        o_strobe  = r_state == ST_EMIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_row  <= i_head.item.row;
                r_col  <= i_head.item.col;
                r_byte <= ALL_ONES;
                r_flag <= i_head.item.kind != K_FILL_BAD;
            end
            ST_MUL_A: r_pa <= pa_full;
            ST_MUL_B: r_pb <= pb_full;
            ST_CMP:   r_wd <= cmp_ge;
            ST_CROP: begin
                // The quotient never falls below the box size on the cropped axis.
                if (div_done) begin
                    r_crop <= (div_q - (r_wd ? PROD_W'(i_cfg.th) : PROD_W'(i_cfg.tw))) >> 1;
                end
            end
            ST_ROW_MUL: r_prod <= mul_full[PROD_W-1:0];
            ST_ROW_DIV: begin
                if (div_done) begin
                    r_sy <= sy_clamp;
                end
            end
            ST_ROW_BASE: begin
                r_base <= ADDR_W'(base_full);
                r_k    <= '0;
            end
            ST_PIX_MUL: begin
                if (dx_skip) begin
                    r_k <= r_k + 1'b1;
                end else begin
                    r_prod <= mul_full[PROD_W-1:0];
                end
            end
            ST_PIX_DIV: begin
                if (div_done) begin
                    r_sx <= sx_clamp;
                end
            end
            ST_PIX_BIT: begin
                if (!src_bit) begin
                    r_byte[K_LAST - r_k] <= 1'b0;
                end
                r_k <= r_k + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_pixel_byte   = r_byte;
    assign o_config_valid = r_flag;

endmodule
`default_nettype wire
